>>> rtl/assert_macros.svh
// assertion macros for the rtl files
// no dependencies; included where concurrent checks are written
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/rhc_pkg.sv
// shared constants and types of the rgb hue cycle led controller
// no dependencies
package rhc_pkg;

	localparam logic [1:0] MODE_SWEEP = 2'd0;
	localparam logic [1:0] MODE_RED   = 2'd1;
	localparam logic [1:0] MODE_BLUE  = 2'd2;
	localparam logic [1:0] MODE_GREEN = 2'd3;

	localparam logic [1:0] ACT_TICK = 2'd0;
	localparam logic [1:0] ACT_SW1  = 2'd1;
	localparam logic [1:0] ACT_SW2  = 2'd2;

	localparam logic [2:0] CFG_PERIOD  = 3'd0;
	localparam logic [2:0] CFG_SPAN    = 3'd1;
	localparam logic [2:0] CFG_FLOOR   = 3'd2;
	localparam logic [2:0] CFG_STEP    = 3'd3;
	localparam logic [2:0] CFG_CEILING = 3'd4;
	localparam logic [2:0] CFG_START   = 3'd5;

	localparam logic [8:0] ANGLE_WRAP = 9'd360;
	localparam logic [8:0] SEGMENT    = 9'd120;
	localparam logic [3:0] SPEED_MIN  = 4'd1;
	localparam logic [3:0] SPEED_MAX  = 4'd10;

	// floor(2^21/120): exact after one correction for products below 2^15
	localparam int          RECIP120_SHIFT = 21;
	localparam logic [14:0] RECIP120       = 15'd17476;
	// floor(2^34/1000): exact after one correction for products below 2^24
	localparam int          RECIP1000_SHIFT = 34;
	localparam logic [24:0] RECIP1000       = 25'd17179869;
	localparam logic [23:0] DIV1000         = 24'd1000;

	// load enables of the two width scaling stages
	typedef struct packed {
		logic s5;
		logic s6;
	} scale_en_t;

endpackage

>>> rtl/rhc_scale.sv
// level to pulse width scaling: level * period / 1000, two register stages
// depends on rhc_pkg
module rhc_scale (
	input  logic              clk,
	input  rhc_pkg::scale_en_t en,
	input  logic [7:0]        level,
	input  logic [15:0]       period,
	output logic [15:0]       width
);
	import rhc_pkg::*;

	logic [23:0] x_s5;
	logic [23:0] x_s6;
	logic [14:0] q0_s6;
	logic [48:0] prod;
	logic [23:0] rem;

	assign prod = 49'(x_s5) * 49'(RECIP1000);

	always_ff @(posedge clk) begin
		if (en.s5) begin
			x_s5 <= 24'(level) * 24'(period);
		end
		if (en.s6) begin
			x_s6  <= x_s5;
			q0_s6 <= prod[RECIP1000_SHIFT +: 15];
		end
	end

	// estimate is low by at most one
	assign rem   = x_s6 - 24'(q0_s6) * DIV1000;
	assign width = (rem >= DIV1000) ? 16'(q0_s6) + 16'd1 : 16'(q0_s6);

endmodule

>>> rtl/rgb_hue_cycle_led_controller.sv
// top level of the rgb hue cycle led controller: event state update and result pipeline
// depends on rhc_pkg, rhc_scale and assert_macros.svh
//
// one event word is taken per cycle unless the pipeline is stalled from the output side,
// and each gives one result word, in order, once it leaves stage 7. the mode, speed, hue and
// manual levels are updated in the accept cycle, so events follow each other back to back.
// the color wheel and the width scaling then run in a seven stage pipeline: the divide by
// 120 and the divide by 1000 are reciprocal multiplies with one correction step, each
// multiplier in a stage of its own. every stage holds its word until the next one frees,
// so empty stages keep accepting input while a finished result waits. the wheel uses the
// span and floor in force at the last tick. no clearing pass after reset.
`include "assert_macros.svh"

module rgb_hue_cycle_led_controller (
	input  logic        clk,
	input  logic        arst_n,
	// event input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [3:0] press_count, [7:4] zero
	input  logic [1:0]  s_tuser,   // [1:0] action
	// result output
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // [15:0] red_width, [31:16] blue_width,
	                               // [47:32] green_width, [49:48] current_mode, [55:50] zero
	// configuration write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import rhc_pkg::*;

	// configuration registers
	logic [15:0] period_q;
	logic [7:0]  span_q, floor_q, step_q, ceiling_q, start_q;

	// controller state
	logic [8:0] hue_q;
	logic [3:0] speed_q;
	logic [1:0] mode_q;
	logic [7:0] red_q, blue_q, green_q;
	logic       ticked_q;
	logic [7:0] tspan_q, tfloor_q;   // span and floor seen at the last tick

	// next state
	logic [8:0] hue_n;
	logic [3:0] speed_n;
	logic [1:0] mode_n, sel_mode;
	logic [7:0] red_n, blue_n, green_n;
	logic       ticked_n;
	logic [7:0] tspan_n, tfloor_n;
	logic [7:0] chan, chan_n, chan_dn, chan_up;
	logic [8:0] hue_sum;

	logic [1:0] action;
	logic [3:0] count;
	logic       accept;

	// pipeline valids and readies
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6, rdy_s7;

	// pipeline payload
	logic [1:0]  mode_s1, mode_s2, mode_s3, mode_s4, mode_s5, mode_s6, mode_s7;
	logic        wheel_s1, wheel_s2, wheel_s3;
	logic [8:0]  hue_s1;
	logic [7:0]  span_s1, span_s2, span_s3;
	logic [7:0]  floor_s1, floor_s2, floor_s3;
	logic [7:0]  red_s1, blue_s1, green_s1;
	logic [7:0]  red_s2, blue_s2, green_s2;
	logic [7:0]  red_s3, blue_s3, green_s3;
	logic [7:0]  red_s4, blue_s4, green_s4;
	logic [1:0]  seg_s2, seg_s3;
	logic [14:0] prod_s2, prod_s3;
	logic [7:0]  q0_s3;
	logic [15:0] red_w_s7, blue_w_s7, green_w_s7;

	// wheel logic
	logic [1:0]  seg;
	logic [6:0]  off;
	logic [29:0] rprod;
	logic [14:0] rem120;
	logic [7:0]  quo, rise, fall;
	logic [7:0]  red_l, blue_l, green_l;

	logic [15:0] red_w, blue_w, green_w;
	scale_en_t   sen;

	assign action = s_tuser;
	assign count  = s_tdata[3:0];
	assign accept = s_tvalid && s_tready;

	// ------------------------------------------------------------ configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q  <= 16'd11362;
			span_q    <= 8'd244;
			floor_q   <= 8'd10;
			step_q    <= 8'd8;
			ceiling_q <= 8'd245;
			start_q   <= 8'd127;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PERIOD:  period_q  <= cfg_data;
				CFG_SPAN:    span_q    <= cfg_data[7:0];
				CFG_FLOOR:   floor_q   <= cfg_data[7:0];
				CFG_STEP:    step_q    <= cfg_data[7:0];
				CFG_CEILING: ceiling_q <= cfg_data[7:0];
				CFG_START:   start_q   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------ event update
	// channel steered by the current manual mode
	always_comb begin
		unique case (mode_q)
			MODE_RED:  chan = red_q;
			MODE_BLUE: chan = blue_q;
			default:   chan = green_q;
		endcase
	end

	assign chan_dn  = chan - step_q;
	assign chan_up  = chan + step_q;
	assign hue_sum  = hue_q + 9'(speed_q);
	assign sel_mode = (count >= 4'd3) ? MODE_GREEN : count[1:0];

	always_comb begin
		hue_n    = hue_q;
		speed_n  = speed_q;
		mode_n   = mode_q;
		red_n    = red_q;
		blue_n   = blue_q;
		green_n  = green_q;
		ticked_n = ticked_q;
		tspan_n  = tspan_q;
		tfloor_n = tfloor_q;
		chan_n   = chan;
		if (action == ACT_SW2 && count != 4'd0) begin
			// mode select; reselecting the current mode keeps the levels
			if (sel_mode != mode_q) begin
				mode_n  = sel_mode;
				red_n   = (sel_mode == MODE_RED)   ? start_q : floor_q;
				blue_n  = (sel_mode == MODE_BLUE)  ? start_q : floor_q;
				green_n = (sel_mode == MODE_GREEN) ? start_q : floor_q;
			end
		end else if (mode_q == MODE_SWEEP) begin
			if (action == ACT_TICK) begin
				hue_n    = (hue_sum >= ANGLE_WRAP) ? 9'd0 : hue_sum;
				ticked_n = 1'b1;
				tspan_n  = span_q;
				tfloor_n = floor_q;
			end else if (action == ACT_SW1) begin
				speed_n = (speed_q > SPEED_MIN) ? speed_q - 4'd1 : SPEED_MIN;
			end else if (action == ACT_SW2) begin
				speed_n = (speed_q >= SPEED_MAX) ? SPEED_MAX : speed_q + 4'd1;
			end
		end else begin
			// manual step of the selected channel, clamped
			if (action == ACT_SW1) begin
				chan_n = (chan_dn < floor_q) ? floor_q : chan_dn;
			end else if (action == ACT_SW2) begin
				chan_n = (chan_up > ceiling_q) ? ceiling_q : chan_up;
			end
			unique case (mode_q)
				MODE_RED:  red_n   = chan_n;
				MODE_BLUE: blue_n  = chan_n;
				default:   green_n = chan_n;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_q    <= 9'd0;
			speed_q  <= 4'd5;
			mode_q   <= MODE_SWEEP;
			red_q    <= 8'd244;
			blue_q   <= 8'd0;
			green_q  <= 8'd0;
			ticked_q <= 1'b0;
			tspan_q  <= 8'd0;
			tfloor_q <= 8'd0;
		end else if (accept) begin
			hue_q    <= hue_n;
			speed_q  <= speed_n;
			mode_q   <= mode_n;
			red_q    <= red_n;
			blue_q   <= blue_n;
			green_q  <= green_n;
			ticked_q <= ticked_n;
			tspan_q  <= tspan_n;
			tfloor_q <= tfloor_n;
		end
	end

	// ------------------------------------------------------------ flow control
	// a stage loads when it is empty or its word moves on
	assign rdy_s7   = !v_s7 || m_tready;
	assign rdy_s6   = !v_s6 || rdy_s7;
	assign rdy_s5   = !v_s5 || rdy_s6;
	assign rdy_s4   = !v_s4 || rdy_s5;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign s_tready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= s_tvalid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
			if (rdy_s6) v_s6 <= v_s5;
			if (rdy_s7) v_s7 <= v_s6;
		end
	end

	// ------------------------------------------------------------ stage 1: post-event state
	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			mode_s1  <= mode_n;
			wheel_s1 <= (mode_n == MODE_SWEEP) && ticked_n;
			hue_s1   <= hue_n;
			span_s1  <= tspan_n;
			floor_s1 <= tfloor_n;
			red_s1   <= red_n;
			blue_s1  <= blue_n;
			green_s1 <= green_n;
		end
	end

	// ------------------------------------------------------------ stage 2: offset * span
	always_comb begin
		if (hue_s1 < SEGMENT) begin
			seg = 2'd0;
			off = 7'(hue_s1);
		end else if (hue_s1 < (SEGMENT << 1)) begin
			seg = 2'd1;
			off = 7'(hue_s1 - SEGMENT);
		end else begin
			seg = 2'd2;
			off = 7'(hue_s1 - (SEGMENT << 1));
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			mode_s2  <= mode_s1;
			wheel_s2 <= wheel_s1;
			seg_s2   <= seg;
			prod_s2  <= 15'(off) * 15'(span_s1);
			span_s2  <= span_s1;
			floor_s2 <= floor_s1;
			red_s2   <= red_s1;
			blue_s2  <= blue_s1;
			green_s2 <= green_s1;
		end
	end

	// ------------------------------------------------------------ stage 3: reciprocal of 120
	assign rprod = 30'(prod_s2) * 30'(RECIP120);

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			mode_s3  <= mode_s2;
			wheel_s3 <= wheel_s2;
			seg_s3   <= seg_s2;
			prod_s3  <= prod_s2;
			q0_s3    <= rprod[RECIP120_SHIFT +: 8];
			span_s3  <= span_s2;
			floor_s3 <= floor_s2;
			red_s3   <= red_s2;
			blue_s3  <= blue_s2;
			green_s3 <= green_s2;
		end
	end

	// ------------------------------------------------------------ stage 4: wheel levels
	assign rem120 = prod_s3 - 15'(q0_s3) * 15'(SEGMENT);
	assign quo    = (rem120 >= 15'(SEGMENT)) ? q0_s3 + 8'd1 : q0_s3;
	assign rise   = floor_s3 + quo;
	assign fall   = floor_s3 + span_s3 - rise;

	always_comb begin
		red_l   = red_s3;
		blue_l  = blue_s3;
		green_l = green_s3;
		if (wheel_s3) begin
			unique case (seg_s3)
				2'd0: begin
					green_l = rise;
					red_l   = fall;
					blue_l  = floor_s3;
				end
				2'd1: begin
					blue_l  = rise;
					green_l = fall;
					red_l   = floor_s3;
				end
				default: begin
					red_l   = rise;
					blue_l  = fall;
					green_l = floor_s3;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			mode_s4  <= mode_s3;
			red_s4   <= red_l;
			blue_s4  <= blue_l;
			green_s4 <= green_l;
		end
	end

	// ------------------------------------------------------------ stages 5 and 6: widths
	assign sen.s5 = rdy_s5;
	assign sen.s6 = rdy_s6;

	rhc_scale u_scale_red (
		.clk    (clk),
		.en     (sen),
		.level  (red_s4),
		.period (period_q),
		.width  (red_w)
	);

	rhc_scale u_scale_blue (
		.clk    (clk),
		.en     (sen),
		.level  (blue_s4),
		.period (period_q),
		.width  (blue_w)
	);

	rhc_scale u_scale_green (
		.clk    (clk),
		.en     (sen),
		.level  (green_s4),
		.period (period_q),
		.width  (green_w)
	);

	always_ff @(posedge clk) begin
		if (rdy_s5) mode_s5 <= mode_s4;
		if (rdy_s6) mode_s6 <= mode_s5;
	end

	// ------------------------------------------------------------ stage 7: output word
	always_ff @(posedge clk) begin
		if (rdy_s7) begin
			mode_s7    <= mode_s6;
			red_w_s7   <= red_w;
			blue_w_s7  <= blue_w;
			green_w_s7 <= green_w;
		end
	end

	assign m_tvalid = v_s7;
	assign m_tdata  = {6'd0, mode_s7, green_w_s7, blue_w_s7, red_w_s7};

	// ------------------------------------------------------------ checks
	`ASSERT_IMPL(a_speed_range, clk, arst_n, 1'b1, (speed_q >= SPEED_MIN && speed_q <= SPEED_MAX), "sweep speed out of range")
	`ASSERT_IMPL(a_hue_range, clk, arst_n, 1'b1, (hue_q < ANGLE_WRAP), "hue angle past wrap")
	`ASSERT_NEXT(a_no_sweep_return, clk, arst_n, (mode_q != MODE_SWEEP), (mode_q != MODE_SWEEP), "sweep mode re-entered")
	`ASSERT_IMPL(a_ready_when_empty, clk, arst_n, !m_tvalid, s_tready, "input stalled with empty output")

endmodule
